### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mcpwm_pkg.sv
// types and constants for the multichannel pwm block
package mcpwm_pkg;

  localparam int BYTE_W = 8;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_BYTE = 1'b1
  } func_t;

  typedef struct packed {
    func_t             func;
    logic [BYTE_W-1:0] link_byte;
  } req_t;

endpackage

### src/multichannel_pwm_with_byte_load.sv
// Multichannel PWM block loaded over a byte link. Every request yields one
// result in the cycle after acceptance: a tick request (func 0) compares each
// channel's duty level against the shared phase counter and returns the new
// output vector, then steps the counter; a link byte request (func 1) is
// taken alternately as channel number and duty level and returns the current
// vector unchanged. One request is taken per cycle; the single result
// register sets that rate, so in_ready drops only while a result waits for
// out_ready.
module multichannel_pwm_with_byte_load import mcpwm_pkg::*; #(
  parameter int CHANNELS     = 18,
  parameter int COUNTER_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [BYTE_W-1:0]   link_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHANNELS-1:0] pwm_outputs
);

  logic                req_accept;
  req_t                req;
  logic [CHANNELS-1:0] result_vec;

  assign req_accept    = in_valid && in_ready;
  assign req.func      = func_t'(func);
  assign req.link_byte = link_byte;

  mcpwm_core #(
    .CHANNELS    (CHANNELS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_accept(req_accept),
    .req       (req),
    .result_vec(result_vec)
  );

  mcpwm_out_reg #(
    .WIDTH(CHANNELS)
  ) u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (req_accept),
    .load_data(result_vec),
    .can_load (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (pwm_outputs)
  );

endmodule

### src/mcpwm_core.sv
// duty store, phase counter, byte receiver and pwm compare
`include "assert_macros.svh"

module mcpwm_core import mcpwm_pkg::*; #(
  parameter int CHANNELS     = 18,
  parameter int COUNTER_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_accept,
  input  req_t                req,
  output logic [CHANNELS-1:0] result_vec
);

  localparam int CMP_W = (COUNTER_BITS > BYTE_W) ? COUNTER_BITS : BYTE_W;
  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [BYTE_W-1:0] CH_LIMIT = BYTE_W'(CHANNELS);

  logic [BYTE_W-1:0]       duty_levels [CHANNELS];
  logic [COUNTER_BITS-1:0] phase_counter;
  logic                    expect_value;
  logic [BYTE_W-1:0]       selected_channel;
  logic [CHANNELS-1:0]     output_vector;

  logic [CHANNELS-1:0] tick_vec;
  logic                is_tick;
  logic                is_byte;
  logic                duty_write;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      tick_vec[ch] = CMP_W'(duty_levels[ch]) < CMP_W'(phase_counter);
    end
  end

  assign is_tick    = req_accept && (req.func == FUNC_TICK);
  assign is_byte    = req_accept && (req.func == FUNC_BYTE);
  assign duty_write = is_byte && expect_value && (selected_channel < CH_LIMIT);
  assign result_vec = (req.func == FUNC_TICK) ? tick_vec : output_vector;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_counter    <= '0;
      expect_value     <= 1'b0;
      selected_channel <= '0;
      output_vector    <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        duty_levels[ch] <= '0;
      end
    end else begin
      if (is_tick) begin
        output_vector <= tick_vec;
        phase_counter <= phase_counter + 1'b1;
      end
      if (is_byte) begin
        expect_value <= !expect_value;
        if (!expect_value) begin
          selected_channel <= req.link_byte;
        end
      end
      if (duty_write) begin
        duty_levels[selected_channel[IDX_W-1:0]] <= req.link_byte;
      end
    end
  end

  `ASSERT_NEXT(a_counter_step, clk, rst, is_tick,
    phase_counter == COUNTER_BITS'($past(phase_counter) + 1'b1),
    "phase counter did not advance on tick")
  `ASSERT_NEXT(a_byte_keeps_vec, clk, rst, is_byte,
    $stable(output_vector) && $stable(phase_counter),
    "link byte changed pwm state")
  `ASSERT_NEXT(a_receiver_toggle, clk, rst, is_byte,
    expect_value != $past(expect_value),
    "receiver did not alternate")

endmodule

### src/mcpwm_out_reg.sv
// result register between pwm logic and output channel
`include "assert_macros.svh"

module mcpwm_out_reg #(
  parameter int WIDTH = 18
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [WIDTH-1:0] load_data,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

  `ASSERT_NEXT(a_load_shows, clk, rst, load,
    out_valid && (out_data == $past(load_data)),
    "loaded result not presented")

endmodule

### verif/tb.sv
// testbench for multichannel_pwm_with_byte_load: random requests checked against a duty predictor
module tb import mcpwm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CH         = 18;
  localparam int CNT_BITS   = 8;
  localparam int N_RANDOM   = 830;
  localparam int N_QUIET    = 200;
  localparam int CYCLE_CAP  = 100000;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic            func;
  logic [7:0]      link_byte;
  logic            out_valid;
  logic            out_ready;
  logic [CH-1:0]   pwm_outputs;

  multichannel_pwm_with_byte_load #(
    .CHANNELS    (CH),
    .COUNTER_BITS(CNT_BITS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .link_byte  (link_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pwm_outputs(pwm_outputs)
  );

  // predictor state
  logic [7:0]          duty_lvl [CH];
  logic [CNT_BITS-1:0] phase;
  logic                want_value;
  logic [7:0]          sel_ch;
  logic [CH-1:0]       pwm_vec;

  req_t          req_q [$];
  logic [CH-1:0] pwm_q [$];
  logic [CH-1:0] want;
  req_t          cur;
  bit            quiet;
  int            send_gap;
  int            recv_gap;
  int            errors;
  int            cycles;
  int            n_ticks, n_bytes, n_writes, n_dropped, n_wraps, n_results;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [CH-1:0] pwm_predict(req_t r);
    logic [CH-1:0] v;
    v = '0;
    if (r.func == FUNC_TICK) begin
      for (int c = 0; c < CH; c++)
        if (duty_lvl[c] < phase) v[c] = 1'b1;
      pwm_vec = v;
      phase = phase + 1'b1;
      if (phase == '0) n_wraps++;
      n_ticks++;
    end else begin
      n_bytes++;
      if (!want_value) begin
        sel_ch = r.link_byte;
        want_value = 1'b1;
      end else begin
        if (sel_ch < CH) begin
          duty_lvl[sel_ch] = r.link_byte;
          n_writes++;
        end else begin
          n_dropped++;
        end
        want_value = 1'b0;
      end
    end
    return pwm_vec;
  endfunction

  task automatic push_req(func_t f, logic [7:0] b);
    req_t r;
    r.func = f;
    r.link_byte = b;
    req_q.push_back(r);
  endtask

  task automatic push_random(int n);
    int k;
    int pick;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        push_req(FUNC_TICK, 8'($urandom));
        k++;
      end else if (pick < 85) begin
        // channel then duty, sometimes a tick in between
        push_req(FUNC_BYTE, 8'($urandom_range(0, CH - 1)));
        if ($urandom_range(0, 4) == 0) begin
          push_req(FUNC_TICK, 8'($urandom));
          k++;
        end
        case ($urandom_range(0, 5))
          0:       push_req(FUNC_BYTE, 8'h00);
          1:       push_req(FUNC_BYTE, 8'hFF);
          default: push_req(FUNC_BYTE, 8'($urandom));
        endcase
        k += 2;
      end else if (pick < 93) begin
        push_req(FUNC_BYTE, 8'($urandom_range(CH, 255)));
        push_req(FUNC_BYTE, 8'($urandom));
        k += 2;
      end else begin
        // lone byte shifts the pairing
        push_req(FUNC_BYTE, 8'($urandom));
        k++;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      func      <= 1'b0;
      link_byte <= 8'h00;
      send_gap  = 0;
    end else begin
      if (in_valid && in_ready) begin
        cur.func = func_t'(func);
        cur.link_byte = link_byte;
        pwm_q.push_back(pwm_predict(cur));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur = req_q.pop_front();
          in_valid  <= 1'b1;
          func      <= cur.func;
          link_byte <= cur.link_byte;
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pwm_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, pwm_outputs);
          errors++;
        end else begin
          want = pwm_q.pop_front();
          if (pwm_outputs !== want) begin
            $display("%0t: pwm_outputs mismatch, expected %h actual %h",
                     $time, want, pwm_outputs);
            errors++;
          end
        end
      end
      if (quiet) begin
        out_ready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 5) == 0) recv_gap = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("multichannel_pwm_with_byte_load: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    func = 1'b0;
    link_byte = 8'h00;
    out_ready = 1'b0;
    quiet = 1'b0;
    errors = 0;
    cycles = 0;
    n_ticks = 0; n_bytes = 0; n_writes = 0; n_dropped = 0; n_wraps = 0; n_results = 0;
    for (int c = 0; c < CH; c++) duty_lvl[c] = 8'h00;
    phase = '0;
    want_value = 1'b0;
    sel_ch = 8'h00;
    pwm_vec = '0;

    // directed: counter at zero, duty zero, extremes, out of range channels
    push_req(FUNC_TICK, 8'hFF);
    push_req(FUNC_TICK, 8'h00);
    push_req(FUNC_BYTE, 8'd0);
    push_req(FUNC_BYTE, 8'hFF);
    push_req(FUNC_BYTE, 8'd17);
    push_req(FUNC_BYTE, 8'h00);
    push_req(FUNC_BYTE, 8'd18);
    push_req(FUNC_BYTE, 8'd7);
    push_req(FUNC_BYTE, 8'hFF);
    push_req(FUNC_BYTE, 8'd128);
    push_req(FUNC_BYTE, 8'd5);
    push_req(FUNC_BYTE, 8'd1);
    push_req(FUNC_BYTE, 8'd9);
    push_req(FUNC_TICK, 8'h55);
    push_req(FUNC_BYTE, 8'd2);
    push_req(FUNC_TICK, 8'hAA);
    push_req(FUNC_TICK, 8'h00);
    push_req(FUNC_TICK, 8'hFF);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // hold the sender until everything has drained
    while (req_q.size() != 0 || in_valid || pwm_q.size() != 0) @(negedge clk);

    push_random(N_RANDOM - N_QUIET);
    while (req_q.size() != 0) @(negedge clk);
    quiet = 1'b1;
    push_random(N_QUIET);

    while (req_q.size() != 0 || in_valid || pwm_q.size() != 0) @(negedge clk);
    repeat (5) @(posedge clk);

    $display("covered %0d ticks (%0d counter wraps) and %0d link bytes, %0d results checked",
             n_ticks, n_wraps, n_bytes, n_results);
    $display("duty writes %0d, values dropped for out-of-range channel %0d",
             n_writes, n_dropped);
    if (errors == 0) begin
      $display("multichannel_pwm_with_byte_load: match");
    end else begin
      $display("multichannel_pwm_with_byte_load: mismatch");
    end
    $finish;
  end

endmodule
